FILE: design/circular_deque_macros.svh
// Assertion macros shared by the circular deque modules.
// Needs no other file; the using module must have signals named clk and rst_n.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge outside reset.
`define CDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a rising clock edge outside reset.
`define CDQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CDQ_ASSERT(label, prop, msg)
`define CDQ_NEVER(label, cond, msg)
`endif
`endif

FILE: design/cdq_pkg.sv
// Package for the circular deque: request codes, control struct and constants.
// Used by cdq_idx and circular_deque; depends on nothing.
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Widths of the word fields and of the capacity register.
    localparam int REQ_W     = 3;
    localparam int OUT_W     = 32;
    localparam int CAP_REG_W = 7;

    // Configuration port layout.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] CFG_IDX_CAPACITY = '0;
    localparam logic [CAP_REG_W-1:0] CAPACITY_RESET = 7'd64;

    // Data returned on a push, on a failed pop or peek and on an unknown request.
    localparam logic [OUT_W-1:0] DATA_NONE = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_REAR  = 3'd5
    } req_t;

    // Decision taken for one request.
    typedef struct packed {
        logic ok;
        logic mem_rd;
        logic mem_wr;
        logic is_empty;
        logic is_full;
    } req_ctl_t;

endpackage

FILE: design/circular_deque.sv
// Circular deque: an accepted request word passes a pending register and then the result register.
// One request per cycle is accepted while the result side does not stall; each request
// makes one access (one read or one write) to the slot memory, which has one port of each.
// Reset empties the deque and sets capacity to 64; the slot memory is not cleared.
// A capacity write also empties the deque.
`timescale 1ns / 1ps
`include "circular_deque_macros.svh"

module circular_deque #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cdq_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cdq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cdq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // Request channel.
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [cdq_pkg::REQ_W-1:0]       req_type,
    input  logic signed [cdq_pkg::OUT_W-1:0] push_value,
    // Result channel.
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            ok,
    output logic signed [cdq_pkg::OUT_W-1:0] data,
    output logic                            is_empty,
    output logic                            is_full
);
    import cdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CAP_W = (CAP_REG_W > $clog2(DEPTH + 1)) ? CAP_REG_W : $clog2(DEPTH + 1);
    localparam int WIDE_W = (DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W;

    // The capacity register holds the raw value written. The last usable slot
    // index is derived from it, with zero acting as one and anything above the
    // memory depth acting as the depth.
    logic [CAP_REG_W-1:0] capacity_reg;
    logic [CAP_W-1:0]     cap_ext;
    logic [IDX_W-1:0]     cap_last;
    logic                 cfg_write;
    logic                 cfg_clear;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_clear = cfg_write && (paddr[APB_ADDR_W-1:2] == CFG_IDX_CAPACITY);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == CFG_IDX_CAPACITY)
                       ? APB_DATA_W'(capacity_reg) : '0;
    assign cap_ext   = CAP_W'(capacity_reg);

    always_comb
    begin
        priority if (cap_ext == '0)
        begin
            cap_last = '0;
        end
        else if (cap_ext > CAP_W'(DEPTH))
        begin
            cap_last = IDX_W'(DEPTH - 1);
        end
        else
        begin
            cap_last = IDX_W'(cap_ext - CAP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_clear)
        begin
            capacity_reg <= pwdata[CAP_REG_W-1:0];
        end
    end

    // Two-stage flow. At the accepting edge the indices update and the slot
    // memory is written (push) or read (pop, peek). The read data is then out of
    // the memory, and the word moves to the result register when that register is
    // free or its word is taken. A push writes at its own accepting edge, so a later
    // request that reads the same slot always finds the new value; no forwarding is needed.
    logic             pend_valid_reg;
    req_ctl_t         pend_ctl_reg;
    req_ctl_t         ctl;
    logic [IDX_W-1:0] mem_addr;
    logic             pend_adv;
    logic             req_fire;

    logic [OUT_W-1:0]      push_bits;
    logic [WIDE_W-1:0]     push_wide;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [WIDE_W-1:0]     rd_wide;

    assign pend_adv  = !rsp_valid || !rsp_stall;
    assign req_stall = pend_valid_reg && !pend_adv;
    assign req_fire  = req_valid && !req_stall;

    // Values are kept in their low DATA_WIDTH bits and come back zero-extended.
    assign push_bits = push_value;
    assign push_wide = WIDE_W'(push_bits);
    assign rd_wide   = WIDE_W'(rd_data);

    cdq_idx #(
        .DEPTH (DEPTH)
    ) u_idx (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_last  (cap_last),
        .cfg_clear (cfg_clear),
        .req_fire  (req_fire),
        .req_type  (req_type),
        .ctl       (ctl),
        .addr      (mem_addr)
    );

    cdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (req_fire && ctl.mem_wr),
        .waddr (mem_addr),
        .wdata (push_wide[DATA_WIDTH-1:0]),
        .re    (req_fire && ctl.mem_rd),
        .raddr (mem_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_adv)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pend_ctl_reg <= ctl;
        end
    end

    // Result register: the output word waits here while the receiver stalls.
    logic                  rsp_valid_reg;
    logic                  ok_reg;
    logic [OUT_W-1:0]      data_reg;
    logic                  is_empty_reg;
    logic                  is_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (pend_valid_reg && pend_adv)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_reg && pend_adv)
        begin
            ok_reg       <= pend_ctl_reg.ok;
            data_reg     <= pend_ctl_reg.mem_rd ? rd_wide[OUT_W-1:0] : DATA_NONE;
            is_empty_reg <= pend_ctl_reg.is_empty;
            is_full_reg  <= pend_ctl_reg.is_full;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign ok        = ok_reg;
    assign data      = data_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

    `CDQ_ASSERT(a_fail_data, (rsp_valid_reg && !ok_reg) |-> (data_reg == DATA_NONE), "failed request returns data other than all ones")
    `CDQ_NEVER(a_flags_exclusive, rsp_valid_reg && is_empty_reg && is_full_reg, "deque reported both empty and full")

endmodule

FILE: design/cdq_ram.sv
// Slot store of the circular deque: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read, so a stalled result keeps its value.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/cdq_idx.sv
// Head, tail and empty state of the circular deque and the per-request decision.
// Depends on cdq_pkg and circular_deque_macros.svh.
`timescale 1ns / 1ps
`include "circular_deque_macros.svh"

module cdq_idx #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [$clog2(DEPTH)-1:0] cap_last,
    input  logic                     cfg_clear,
    input  logic                     req_fire,
    input  logic [cdq_pkg::REQ_W-1:0] req_type,
    output cdq_pkg::req_ctl_t        ctl,
    output logic [$clog2(DEPTH)-1:0] addr
);
    import cdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [IDX_W-1:0] nxt_head, prv_head, nxt_tail, prv_tail;
    logic             full_now;

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                                input logic [IDX_W-1:0] last);
        return (i == last) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                  input logic [IDX_W-1:0] last);
        return (i == '0) ? last : i - IDX_W'(1);
    endfunction

    assign nxt_head = step_up(head_reg, cap_last);
    assign prv_head = step_down(head_reg, cap_last);
    assign nxt_tail = step_up(tail_reg, cap_last);
    assign prv_tail = step_down(tail_reg, cap_last);
    assign full_now = !empty_reg && (nxt_tail == head_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ctl        = '0;
        addr       = head_reg;
        unique case (req_t'(req_type))
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (!full_now)
                begin
                    ctl.ok     = 1'b1;
                    ctl.mem_wr = 1'b1;
                    if (empty_reg)
                    begin
                        // The first element always lands in slot zero.
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        addr       = '0;
                    end
                    else if (req_t'(req_type) == REQ_PUSH_FRONT)
                    begin
                        head_next = prv_head;
                        addr      = prv_head;
                    end
                    else
                    begin
                        tail_next = nxt_tail;
                        addr      = nxt_tail;
                    end
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR:
            begin
                if (!empty_reg)
                begin
                    ctl.ok     = 1'b1;
                    ctl.mem_rd = 1'b1;
                    addr = (req_t'(req_type) == REQ_POP_FRONT) ? head_reg : tail_reg;
                    if (head_reg == tail_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end
                    else if (req_t'(req_type) == REQ_POP_FRONT)
                    begin
                        head_next = nxt_head;
                    end
                    else
                    begin
                        tail_next = prv_tail;
                    end
                end
            end
            REQ_PEEK_FRONT, REQ_PEEK_REAR:
            begin
                if (!empty_reg)
                begin
                    ctl.ok     = 1'b1;
                    ctl.mem_rd = 1'b1;
                    addr = (req_t'(req_type) == REQ_PEEK_FRONT) ? head_reg : tail_reg;
                end
            end
            default:
            begin
            end
        endcase
        ctl.is_empty = empty_next;
        ctl.is_full  = !empty_next && (step_up(tail_next, cap_last) == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (cfg_clear)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (req_fire)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    `CDQ_ASSERT(a_empty_at_origin, empty_reg |-> (head_reg == '0 && tail_reg == '0), "empty deque with indices away from slot zero")
    `CDQ_ASSERT(a_index_range, (head_reg <= cap_last && tail_reg <= cap_last), "index beyond capacity")
    `CDQ_ASSERT(a_push_fills, (req_fire && ctl.mem_wr && !cfg_clear) |=> !empty_reg, "deque empty after a stored push")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for circular_deque: drives request words, predicts every result
// word with its own deque model and checks them in order. Needs cdq_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
    import cdq_pkg::*;

    // Request codes that the block does not define. They must change nothing.
    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    // Traffic mixes for the random part: mostly pushes, mostly pops, or balanced.
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;

    localparam int SLOT_COUNT = DEPTH_DEF;

    // One expected result word.
    typedef struct {
        logic             ok;
        logic [OUT_W-1:0] data;
        logic             empty;
        logic             full;
    } deque_result_t;

    // Every block input starts at a known value.
    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr      = '0;
    logic [APB_DATA_W-1:0]  pwdata     = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   req_valid  = 1'b0;
    logic                   req_stall;
    logic [REQ_W-1:0]       req_type   = '0;
    logic signed [OUT_W-1:0] push_value = '0;
    logic                   rsp_valid;
    logic                   rsp_stall  = 1'b0;
    logic                   ok;
    logic signed [OUT_W-1:0] data;
    logic                   is_empty;
    logic                   is_full;

    // Shadow copy of the deque, updated as each request word is accepted.
    logic [OUT_W-1:0]       shadow_slots [SLOT_COUNT];
    int unsigned            shadow_head;
    int unsigned            shadow_tail;
    bit                     shadow_empty;
    logic [CAP_REG_W-1:0]   shadow_cap;

    // Results still owed by the block, oldest first.
    deque_result_t          expected_responses [$];

    int                     error_count;
    int                     send_idle_pct;
    int                     rsp_idle_pct;

    circular_deque dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .push_value (push_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .ok         (ok),
        .data       (data),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The result side stalls at random; the rate is set per phase of the run.
    always @(posedge clk)
    begin
        rsp_stall <= (rsp_idle_pct != 0) && ($urandom_range(99) < rsp_idle_pct);
    end

    // A generous ceiling on the whole run. A healthy run ends long before this.
    initial
    begin
        #3_200_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Deque predictor
    // ------------------------------------------------------------------

    // Slots actually in use: a capacity of 0 behaves as 1, anything above the
    // store depth behaves as the depth.
    function automatic int unsigned active_slots();
        if (shadow_cap == 0)
            return 1;
        if (shadow_cap > SLOT_COUNT)
            return SLOT_COUNT;
        return shadow_cap;
    endfunction

    function automatic int unsigned step_fwd(input int unsigned idx);
        return (idx + 1 >= active_slots()) ? 0 : idx + 1;
    endfunction

    function automatic int unsigned step_back(input int unsigned idx);
        return (idx == 0) ? active_slots() - 1 : idx - 1;
    endfunction

    // Full means non-empty with the slot after the tail, circularly, being the head.
    function automatic bit shadow_full();
        return !shadow_empty && step_fwd(shadow_tail) == shadow_head;
    endfunction

    function automatic void empty_shadow();
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_empty = 1'b1;
    endfunction

    // Applies one accepted request to the shadow deque and queues the result
    // word that the block must return for it.
    function automatic void predict_deque_response(input logic [REQ_W-1:0] kind,
                                                   input logic [OUT_W-1:0] value);
        deque_result_t rsp;
        int unsigned   at;
        rsp.ok   = 1'b0;
        rsp.data = DATA_NONE;
        case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_REAR:
            begin
                if (!shadow_full())
                begin
                    if (shadow_empty)
                    begin
                        // The first element always lands in slot 0.
                        shadow_head     = 0;
                        shadow_tail     = 0;
                        shadow_empty    = 1'b0;
                        shadow_slots[0] = value;
                    end
                    else if (kind == REQ_PUSH_FRONT)
                    begin
                        shadow_head               = step_back(shadow_head);
                        shadow_slots[shadow_head] = value;
                    end
                    else
                    begin
                        shadow_tail               = step_fwd(shadow_tail);
                        shadow_slots[shadow_tail] = value;
                    end
                    rsp.ok = 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR:
            begin
                if (!shadow_empty)
                begin
                    at       = (kind == REQ_POP_FRONT) ? shadow_head : shadow_tail;
                    rsp.data = shadow_slots[at];
                    rsp.ok   = 1'b1;
                    // Taking the last element resets both indices.
                    if (shadow_head == shadow_tail)
                        empty_shadow();
                    else if (kind == REQ_POP_FRONT)
                        shadow_head = step_fwd(shadow_head);
                    else
                        shadow_tail = step_back(shadow_tail);
                end
            end
            REQ_PEEK_FRONT, REQ_PEEK_REAR:
            begin
                if (!shadow_empty)
                begin
                    at       = (kind == REQ_PEEK_FRONT) ? shadow_head : shadow_tail;
                    rsp.data = shadow_slots[at];
                    rsp.ok   = 1'b1;
                end
            end
            default:
            begin
                // Undefined codes leave the deque alone and only report the flags.
            end
        endcase
        rsp.empty = shadow_empty;
        rsp.full  = shadow_full();
        expected_responses.push_back(rsp);
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    // Handshake signals are sampled at the clock edge, before any of this
    // edge's updates land, so the sample is the value the block saw.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t: unexpected result word: ok %0b data %h empty %0b full %0b",
                         $time, ok, data, is_empty, is_full);
                error_count++;
            end
            else
            begin
                want = expected_responses.pop_front();
                if (ok !== want.ok)
                begin
                    $display("%0t: ok mismatch: expected %0b actual %0b",
                             $time, want.ok, ok);
                    error_count++;
                end
                if (data !== want.data)
                begin
                    $display("%0t: data mismatch: expected %h actual %h",
                             $time, want.data, data);
                    error_count++;
                end
                if (is_empty !== want.empty)
                begin
                    $display("%0t: is_empty mismatch: expected %0b actual %0b",
                             $time, want.empty, is_empty);
                    error_count++;
                end
                if (is_full !== want.full)
                begin
                    $display("%0t: is_full mismatch: expected %0b actual %0b",
                             $time, want.full, is_full);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Sends one request word. The sender may first idle at random; once valid
    // is up, the word is held until the block takes it.
    // Called and returning at a rising edge.
    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [OUT_W-1:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        push_value <= value;
        do
            @(posedge clk);
        while (req_stall);
        predict_deque_response(kind, value);
    endtask

    // Holds the sender off until every owed result word has come back, then lets the
    // pipeline settle.
    task automatic finish_pending();
        req_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the capacity register on the configuration port, then reads it
    // back. Only done with the block idle. The write also empties the deque.
    task automatic write_capacity(input logic [CAP_REG_W-1:0] cap_value);
        finish_pending();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_CAPACITY, 2'b00};
        pwdata  <= APB_DATA_W'(cap_value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_cap = cap_value;
        empty_shadow();
        // Read-back: a fresh setup phase with the same select.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[CAP_REG_W-1:0] !== cap_value)
        begin
            $display("%0t: capacity read-back mismatch: expected %0d actual %0d",
                     $time, cap_value, prdata[CAP_REG_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random push value, with the sign and range extremes appearing often.
    function automatic logic [OUT_W-1:0] pick_value();
        case ($urandom_range(11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Random request code, weighted by the current traffic mix. A few percent
    // are undefined codes as noise.
    function automatic logic [REQ_W-1:0] pick_kind(input int mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll     = $urandom_range(99);
        push_pct = (mix == MIX_GROW) ? 65 : (mix == MIX_SHRINK) ? 15 : 40;
        pop_pct  = (mix == MIX_SHRINK) ? 65 : (mix == MIX_GROW) ? 15 : 40;
        if (roll < push_pct)
            return $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
        roll -= push_pct;
        if (roll < pop_pct)
            return $urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT;
        roll -= pop_pct;
        if (roll < 15)
            return $urandom_range(1) ? REQ_PEEK_REAR : REQ_PEEK_FRONT;
        return $urandom_range(1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // At the reset capacity: pops and peeks on an empty deque, undefined codes,
    // pushes of extreme values at both ends, then peeks and pops down to empty and beyond.
    task automatic test_basic_requests();
        send_word(REQ_PEEK_FRONT, '0);
        send_word(REQ_POP_FRONT,  '0);
        send_word(REQ_UNUSED_6,   32'h1234_5678);
        send_word(REQ_UNUSED_7,   '1);
        send_word(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(REQ_PUSH_REAR,  32'h8000_0000);
        send_word(REQ_PUSH_FRONT, '0);
        send_word(REQ_PUSH_REAR,  '1);
        send_word(REQ_PEEK_FRONT, '0);
        send_word(REQ_PEEK_REAR,  '0);
        send_word(REQ_POP_FRONT,  '0);
        send_word(REQ_POP_REAR,   '0);
        send_word(REQ_POP_FRONT,  '0);
        // The last element leaves; the deque must report empty again.
        send_word(REQ_POP_REAR,   '0);
        send_word(REQ_POP_REAR,   '0);
        send_word(REQ_PEEK_REAR,  '0);
    endtask

    // Tiny capacities, including 0, which must act as 1. Elements are left in
    // the deque on purpose so that the next capacity write has to empty it.
    task automatic test_small_capacity();
        write_capacity(7'd1);
        send_word(REQ_PUSH_REAR,  32'hA5A5_A5A5);
        send_word(REQ_PUSH_FRONT, 32'h5A5A_5A5A);
        send_word(REQ_POP_FRONT,  '0);
        write_capacity(7'd0);
        send_word(REQ_PUSH_FRONT, 32'h0F0F_0F0F);
        send_word(REQ_PUSH_REAR,  32'hF0F0_F0F0);
        write_capacity(7'd2);
        send_word(REQ_PEEK_FRONT, '0);
        send_word(REQ_PUSH_FRONT, 32'h0000_0001);
        send_word(REQ_PUSH_FRONT, 32'hFFFF_FFFE);
        send_word(REQ_PEEK_REAR,  '0);
    endtask

    // Fills the deque to its capacity from random ends, tries one push too
    // many, then drains it past empty, again from random ends.
    task automatic test_fill_and_drain(input logic [CAP_REG_W-1:0] cap_value);
        int unsigned count;
        write_capacity(cap_value);
        count = active_slots();
        repeat (count + 1)
            send_word($urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT, pick_value());
        send_word(REQ_PEEK_FRONT, '0);
        send_word(REQ_PEEK_REAR,  '0);
        repeat (count + 1)
            send_word($urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT, '0);
    endtask

    // Random traffic in bursts, each burst with its own mix so that the deque
    // swings between empty and full.
    task automatic test_random_traffic(input logic [CAP_REG_W-1:0] cap_value, input int count);
        int mix;
        int burst;
        write_capacity(cap_value);
        mix   = MIX_EVEN;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                mix   = $urandom_range(2);
                burst = $urandom_range(8, 40);
            end
            burst--;
            send_word(pick_kind(mix), pick_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        error_count   = 0;
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        shadow_cap    = CAPACITY_RESET;
        empty_shadow();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Sender mostly busy, receiver stalling most of the time.
        send_idle_pct = 25;
        rsp_idle_pct  = 80;
        test_basic_requests();
        test_small_capacity();
        test_fill_and_drain(7'd127);
        test_random_traffic(7'd1, 90);
        test_random_traffic(7'd3, 90);
        test_random_traffic(7'd40, 90);

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 80;
        rsp_idle_pct  = 25;
        test_fill_and_drain(7'd64);
        test_random_traffic(7'd0, 90);
        test_random_traffic(7'd2, 90);
        test_random_traffic(7'd17, 90);

        // Back-to-back traffic with no idling on either side.
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        test_random_traffic(7'd65, 90);
        test_random_traffic(CAP_REG_W'($urandom_range(1, SLOT_COUNT)), 90);
        test_random_traffic(7'd5, 90);
        test_random_traffic(7'd64, 90);

        // Wait for the last results, then give stray words time to show up.
        finish_pending();
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
